// ===== design/xrr_pkg.sv =====
`timescale 1ns / 1ps
package xrr_pkg;

   localparam int WORD_W       = 32;
   localparam int RANGE_W      = 31;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int WARMUP_STEPS = 100;
   localparam int WARM_W       = $clog2(WARMUP_STEPS + 2);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_CNT_W    = $clog2(WORD_W);

   localparam int SHIFT_X_LEFT  = 11;
   localparam int SHIFT_W_RIGHT = 19;
   localparam int SHIFT_T_RIGHT = 8;

   localparam logic [WORD_W-1:0] INIT_X = 32'd123456789;
   localparam logic [WORD_W-1:0] INIT_Y = 32'd362436069;
   localparam logic [WORD_W-1:0] INIT_Z = 32'd521288629;
   localparam logic [WORD_W-1:0] INIT_W = 32'd88675123;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SEED_ZERO  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_B = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_C = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED_D = 2'd3;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_RESEED = 1'b1;

   typedef enum logic [1:0] {
      OP_DRAW       = 2'd0,
      OP_RANGE_ZERO = 2'd1,
      OP_RESEED     = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [RANGE_W-1:0] range;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] w;
   } gen_state_type;

   function automatic gen_state_type gen_step(input gen_state_type s);
      logic [WORD_W-1:0] t;
      gen_state_type     n;
      t   = s.x ^ (s.x << SHIFT_X_LEFT);
      n.x = s.y;
      n.y = s.z;
      n.z = s.w;
      n.w = (s.w ^ (s.w >> SHIFT_W_RIGHT)) ^ (t ^ (t >> SHIFT_T_RIGHT));
      return n;
   endfunction

endpackage

// ===== design/xrr_req_if.sv =====
`timescale 1ns / 1ps
interface xrr_req_if;
   import xrr_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [RANGE_W-1:0] range;

   modport source (output valid, kind, range, input ready);
   modport sink (input valid, kind, range, output ready);
endinterface

// ===== design/xrr_rsp_if.sv =====
`timescale 1ns / 1ps
interface xrr_rsp_if;
   import xrr_pkg::*;

   logic                valid;
   logic                ready;
   logic [RANGE_W-1:0]  value;
   logic [STATUS_W-1:0] status;

   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

// ===== design/xrr_front.sv =====
`timescale 1ns / 1ps
module xrr_front (
   xrr_req_if.sink           req_port,
   input  logic              queue_full,
   output xrr_pkg::push_type push
);
   import xrr_pkg::*;

   assign req_port.ready = !queue_full;

   always_comb begin
      push.valid     = req_port.valid && !queue_full;
      push.cmd.range = req_port.range;
      if (req_port.kind == KIND_RESEED) begin
         push.cmd.op = OP_RESEED;
      end else if (req_port.range == '0) begin
         push.cmd.op = OP_RANGE_ZERO;
      end else begin
         push.cmd.op = OP_DRAW;
      end
   end
endmodule

// ===== design/xrr_queue.sv =====
`timescale 1ns / 1ps
module xrr_queue (
   input  logic              clock,
   input  logic              reset,
   input  xrr_pkg::push_type push,
   output logic              full,
   output xrr_pkg::head_type head,
   input  logic              pop
);
   import xrr_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push offered while queue full");
`endif
endmodule

// ===== design/xrr_divider.sv =====
`timescale 1ns / 1ps
module xrr_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [xrr_pkg::WORD_W-1:0]  dividend,
   input  logic [xrr_pkg::RANGE_W-1:0] divisor,
   output logic                        busy,
   output logic                        done,
   output logic [xrr_pkg::RANGE_W-1:0] remainder
);
   import xrr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RANGE_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]    dvd_ff, dvd_in;
   logic [RANGE_W-1:0]   dsr_ff, dsr_in;
   logic [WORD_W-1:0]    shifted;
   logic [WORD_W:0]      diff;

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   // restoring division, one quotient bit per cycle; only the remainder is kept
   assign shifted = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(WORD_W - 1);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[WORD_W] ? shifted[RANGE_W-1:0] : diff[RANGE_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");
`endif
endmodule

// ===== design/xrr_back.sv =====
`timescale 1ns / 1ps
module xrr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  xrr_pkg::head_type      head,
   output logic                   pop,
   input  xrr_pkg::gen_state_type seeds,
   xrr_rsp_if.source              rsp_port
);
   import xrr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_REST = 6'b000010,
      ST_STEP = 6'b000100,
      ST_MOD  = 6'b001000,
      ST_WARM = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   gen_state_type       gen_ff, gen_in, gen_next;
   logic [RANGE_W-1:0]  range_ff, range_in;
   logic [RANGE_W-1:0]  rest_ff, rest_in;
   logic [WARM_W-1:0]   warm_ff, warm_in;
   logic [RANGE_W-1:0]  res_value_ff, res_value_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RANGE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                out_free;
   logic                div_start, div_busy, div_done;
   logic [WORD_W-1:0]   div_dividend;
   logic [RANGE_W-1:0]  div_divisor, div_rem;

   assign gen_next = gen_step(gen_ff);
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   xrr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      gen_in        = gen_ff;
      range_in      = range_ff;
      rest_in       = rest_ff;
      warm_in       = warm_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      pop           = 1'b0;
      div_start     = 1'b0;
      div_dividend  = '1;
      div_divisor   = range_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop           = 1'b1;
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               case (head.cmd.op)
                  OP_DRAW: begin
                     // rest = 0xFFFFFFFF mod range
                     range_in    = head.cmd.range;
                     div_divisor = head.cmd.range;
                     div_start   = 1'b1;
                     state_in    = ST_REST;
                  end
                  OP_RESEED: begin
                     if ((seeds.x | seeds.y | seeds.z | seeds.w) == '0) begin
                        res_status_in = STATUS_SEED_ZERO;
                        state_in      = ST_OUT;
                     end else begin
                        gen_in   = seeds;
                        warm_in  = WARM_W'(WARMUP_STEPS);
                        state_in = ST_WARM;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_RANGE_ZERO;
                     state_in      = ST_OUT;
                  end
               endcase
            end
         end
         ST_REST: begin
            if (div_done) begin
               rest_in  = div_rem;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            gen_in = gen_next;
            if (gen_next.w >= {1'b0, rest_ff}) begin
               div_dividend = gen_next.w;
               div_start    = 1'b1;
               state_in     = ST_MOD;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               res_value_in = div_rem;
               state_in     = ST_OUT;
            end
         end
         ST_WARM: begin
            if (warm_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               gen_in  = gen_next;
               warm_in = warm_ff - 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         warm_ff      <= '0;
         gen_ff       <= '{x: INIT_X, y: INIT_Y, z: INIT_Z, w: INIT_W};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         warm_ff      <= warm_in;
         gen_ff       <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      range_ff      <= range_in;
      rest_ff       <= rest_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.value  = rsp_value_ff;
   assign rsp_port.status = rsp_status_ff;

`ifndef SYNTH
   a_gen_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> ((gen_ff.x | gen_ff.y | gen_ff.z | gen_ff.w) != '0))
      else $error("generator state went all zero");
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_value_ff == '0))
      else $error("error result carries nonzero value");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && !div_done) |-> div_busy)
      else $error("waiting on a divider that is not running");
`endif
endmodule

// ===== design/xorshift128_range_rng.sv =====
// Xorshift128 generator with uniform range reduction; one request is worked at a time.
// Draw: bit-serial rest = 0xFFFFFFFF mod range; words below rest rejected; word mod range.
// Reseed warms up from the seed words; range zero and all-zero seed reply with an error.
// A 2-entry request queue accepts until full while the back end works or a result waits.
// Synchronous active-high reset: seeds clear to 0, generator returns to its default words.
`timescale 1ns / 1ps
module xorshift128_range_rng (
   input  logic                            clock,
   input  logic                            reset,
   xrr_req_if.sink                         req_port,
   xrr_rsp_if.source                       rsp_port,
   input  logic                            csr_write_enable,
   input  logic [xrr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [xrr_pkg::WORD_W-1:0]      csr_write_data
);
   import xrr_pkg::*;

   gen_state_type seeds_ff, seeds_in;
   push_type      push;
   head_type      head;
   logic          queue_full;
   logic          pop;

   always_comb begin
      seeds_in = seeds_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SEED_A: seeds_in.x = csr_write_data;
            CSR_SEED_B: seeds_in.y = csr_write_data;
            CSR_SEED_C: seeds_in.z = csr_write_data;
            CSR_SEED_D: seeds_in.w = csr_write_data;
            default: seeds_in = seeds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeds_ff <= '0;
      end else begin
         seeds_ff <= seeds_in;
      end
   end

   xrr_front u_front (
      .req_port   (req_port),
      .queue_full (queue_full),
      .push       (push)
   );

   xrr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   xrr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .seeds    (seeds_ff),
      .rsp_port (rsp_port)
   );
endmodule
